// ===== rtl/deu_pkg.sv =====
// ============================================================================
// deu_pkg: shared types and constants for the digitizer event unpacker
// Holds the word classification passed from the front end to the back end,
// the record kinds and the charge-sum window bounds.
// ============================================================================
`default_nettype none

package deu_pkg;

    // Largest number of charge-sum windows and the sum index width
    localparam int MAX_WINDOWS = 8;
    localparam int SUM_IDX_W   = 3;

    // Entries in the queue between front end and back end
    localparam int QUEUE_DEPTH = 4;

    // Window bounds in samples: window k covers [WIN_BOUND[k], WIN_BOUND[k+1])
    localparam logic [7:0] WIN_BOUND [0:MAX_WINDOWS] = '{
        8'd0, 8'd31, 8'd60, 8'd75, 8'd95, 8'd105, 8'd160, 8'd175, 8'd200
    };

    // What the back end does with one stream word
    typedef enum logic [2:0] {
        OP_NOP,
        OP_HDR0,
        OP_HDR1,
        OP_HDR2,
        OP_HDR3,
        OP_ENERGY,
        OP_CHARGE,
        OP_TRACE
    } t_op_kind;

    // Output record kinds
    typedef enum logic [1:0] {
        REC_HEADER = 2'd0,
        REC_ENERGY = 2'd1,
        REC_CHARGE = 2'd2
    } t_rec_kind;

    // One classified word
    typedef struct packed {
        t_op_kind               kind;
        logic [SUM_IDX_W-1:0]   idx;         // energy or charge sum index
        logic                   lo_hit;      // low sample lands in a window
        logic [SUM_IDX_W-1:0]   lo_win;
        logic                   hi_hit;      // high sample lands in a window
        logic [SUM_IDX_W-1:0]   hi_win;
        logic [31:0]            word;        // raw word, or masked samples for trace
        logic                   last;        // event ends with this word
        logic                   emit_energy; // event carries energy-sum records
        logic                   emit_charge; // event carries charge-sum records
    } t_op;

    // Configuration as seen by the back end
    typedef struct packed {
        logic [3:0] first_slot;
        logic [4:0] channels_per_board;
        logic [9:0] board_span;          // boards_per_crate * channels_per_board
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/deu_front.sv =====
// ============================================================================
// deu_front: word tracker and classifier
// Follows the position inside the current event and turns every accepted
// word into one queue entry that tells the back end what to do with it.
// ============================================================================
`default_nettype none

module deu_front #(
    parameter int SUM_WINDOWS = 8,
    parameter int SAMPLE_BITS = 14
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [31:0]    i_word,
    output deu_pkg::t_op        o_op
);
    import deu_pkg::*;

    localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
    localparam logic [14:0] TRACE_LIMIT = 15'(WIN_BOUND[SUM_WINDOWS]);

    // Event tracking state
    logic [13:0] r_pos,   n_pos;
    logic [4:0]  r_hw,    n_hw;
    logic [13:0] r_ew,    n_ew;
    logic [14:0] r_trlen, n_trlen;

    logic        hdr_q;
    logic        emit_energy;
    logic [14:0] trlen_eff;
    logic [4:0]  hdr_off;
    logic [4:0]  hdr_off_q;
    logic [13:0] start;
    logic [13:0] trace_word;
    logic [14:0] lo_idx;
    logic [14:0] hi_idx;
    t_op         op;

    // Window number of a sample index (below the first bound that exceeds it)
    function automatic logic [SUM_IDX_W-1:0] win_of(input logic [14:0] idx);
        logic [SUM_IDX_W-1:0] c;
        c = '0;
        for (int k = 1; k < MAX_WINDOWS; k++) begin
            if (idx >= 15'(WIN_BOUND[k])) c = c + 1'b1;
        end
        return c;
    endfunction

    // Classification of the current word
    always_comb begin
        hdr_q       = (r_hw == 5'd12) || (r_hw == 5'd16);
        emit_energy = (r_hw == 5'd8)  || (r_hw == 5'd16);
        trlen_eff   = r_trlen;
        start       = (r_hw > 5'd4) ? 14'(r_hw) : 14'd4;
        trace_word  = r_pos - start;
        lo_idx      = {trace_word, 1'b0};
        hi_idx      = {trace_word, 1'b1};
        hdr_off     = 5'(r_pos - 14'd4);
        hdr_off_q   = hdr_off - 5'd4;

        op          = '0;
        op.kind     = OP_NOP;
        op.word     = i_word;
        n_pos       = r_pos + 14'd1;
        n_hw        = r_hw;
        n_ew        = r_ew;
        n_trlen     = r_trlen;

        if (r_pos == 14'd0) begin
            op.kind = OP_HDR0;
            n_hw    = i_word[16:12];
            n_ew    = i_word[30:17];
        end else if (r_pos == 14'd1) begin
            op.kind = OP_HDR1;
        end else if (r_pos == 14'd2) begin
            op.kind = OP_HDR2;
        end else if (r_pos == 14'd3) begin
            op.kind   = OP_HDR3;
            trlen_eff = i_word[30:16];
            n_trlen   = i_word[30:16];
            // header-only event without trace: drop silently
            if (r_hw == 5'd4 && trlen_eff < 15'd2) begin
                n_pos = '0;
            end else if (r_ew <= 14'd4) begin
                op.last = 1'b1;
                n_pos   = '0;
            end
        end else begin
            if (r_pos < 14'(r_hw)) begin
                // optional sums carried in the header
                if (emit_energy && hdr_off < 5'd4) begin
                    op.kind = OP_ENERGY;
                    op.idx  = hdr_off[SUM_IDX_W-1:0];
                end else if (r_hw == 5'd12 && hdr_off < 5'd8
                             && hdr_off < 5'(SUM_WINDOWS)) begin
                    op.kind = OP_CHARGE;
                    op.idx  = hdr_off[SUM_IDX_W-1:0];
                end else if (r_hw == 5'd16 && hdr_off >= 5'd4 && hdr_off < 5'd12
                             && hdr_off_q < 5'(SUM_WINDOWS)) begin
                    op.kind = OP_CHARGE;
                    op.idx  = hdr_off_q[SUM_IDX_W-1:0];
                end
            end else if (!hdr_q) begin
                // trace word: two samples, low half first
                op.kind   = OP_TRACE;
                op.word   = {i_word[31:16] & SAMPLE_MASK, i_word[15:0] & SAMPLE_MASK};
                op.lo_hit = (lo_idx < r_trlen) && (lo_idx < TRACE_LIMIT);
                op.lo_win = win_of(lo_idx);
                op.hi_hit = (hi_idx < r_trlen) && (hi_idx < TRACE_LIMIT);
                op.hi_win = win_of(hi_idx);
            end
            if ((15'(r_pos) + 15'd1) >= 15'(r_ew)) begin
                op.last = 1'b1;
                n_pos   = '0;
            end
        end

        op.emit_energy = emit_energy;
        op.emit_charge = (trlen_eff != 15'd0) || hdr_q;
    end

    assign o_op = op;

    // Tracking registers advance on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hw    <= '0;
            r_ew    <= '0;
            r_trlen <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_hw    <= n_hw;
            r_ew    <= n_ew;
            r_trlen <= n_trlen;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/deu_queue.sv =====
// ============================================================================
// deu_queue: short FIFO of classified words
// Decouples the word classifier from the record generator so that each
// side stalls on its own.
// ============================================================================
`default_nettype none

module deu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  deu_pkg::t_op        i_op,
    output logic                o_ready,
    output logic                o_valid,
    output deu_pkg::t_op        o_op,
    input  wire logic           i_pop
);
    import deu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_op;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_wr_ptr == r_rd_ptr)
        else $error("empty queue with mismatched pointers");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow push");

endmodule

`default_nettype wire

// ===== rtl/deu_back.sv =====
// ============================================================================
// deu_back: sum accumulator and record generator
// Applies classified words to the header and sum registers, then walks out
// the header, energy-sum and charge-sum records of each finished event
// through a registered output stage.
// ============================================================================
`default_nettype none

module deu_back #(
    parameter int SUM_WINDOWS = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  deu_pkg::t_cfg       i_cfg,
    input  wire logic           i_op_valid,
    input  deu_pkg::t_op        i_op,
    output logic                o_op_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [1:0]          o_record_kind,
    output logic [11:0]         o_detector_id,
    output logic                o_finish_code,
    output logic [47:0]         o_timestamp,
    output logic [14:0]         o_cfd_time,
    output logic                o_cfd_fail,
    output logic [15:0]         o_energy,
    output logic [14:0]         o_trace_length,
    output logic                o_out_of_range,
    output logic [2:0]          o_sum_index,
    output logic [31:0]         o_sum_value,
    output logic                o_last_record
);
    import deu_pkg::*;

    typedef enum logic [1:0] {
        S_RUN,
        S_HDR,
        S_ENERGY,
        S_CHARGE
    } t_state;

    t_state               r_state, n_state;
    logic [SUM_IDX_W-1:0] r_sum_idx, n_sum_idx;
    logic                 r_emit_energy;
    logic                 r_emit_charge;

    // Event header and sums
    logic [31:0] r_w0, r_w1, r_w2, r_w3;
    logic [31:0] r_energy [4];
    logic [31:0] r_charge [SUM_WINDOWS];

    // Output stage
    logic                 r_out_valid;
    t_rec_kind            r_out_kind;
    logic [11:0]          r_out_id;
    logic [31:0]          r_out_w0, r_out_w1, r_out_w2, r_out_w3;
    logic [SUM_IDX_W-1:0] r_out_idx;
    logic [31:0]          r_out_sum_value;
    logic                 r_out_last;

    logic                 load;
    logic                 rec_last;
    logic                 pop;
    t_rec_kind            rec_kind;
    logic [31:0]          rec_value;
    logic [31:0]          charge_sel;
    logic [11:0]          crate_part;
    logic [11:0]          slot_part;
    logic [11:0]          det_id;
    logic [15:0]          lo_sample;
    logic [15:0]          hi_sample;

    // Record sequencing
    assign load = (r_state != S_RUN) && (!r_out_valid || i_out_ready);

    always_comb begin
        case (r_state)
            S_HDR:    rec_last = !r_emit_energy && !r_emit_charge;
            S_ENERGY: rec_last = (r_sum_idx == SUM_IDX_W'(3)) && !r_emit_charge;
            S_CHARGE: rec_last = ({1'b0, r_sum_idx} == (SUM_IDX_W+1)'(SUM_WINDOWS - 1));
            default:  rec_last = 1'b0;
        endcase
    end

    // Next word may enter as the last record of an event goes out
    assign pop      = i_op_valid && ((r_state == S_RUN) || (load && rec_last));
    assign o_op_pop = pop;

    // Charge sum selected for output
    always_comb begin
        charge_sel = '0;
        for (int k = 0; k < SUM_WINDOWS; k++) begin
            if (r_sum_idx == SUM_IDX_W'(k)) charge_sel = r_charge[k];
        end
    end

    always_comb begin
        case (r_state)
            S_ENERGY: begin
                rec_kind  = REC_ENERGY;
                rec_value = r_energy[r_sum_idx[1:0]];
            end
            S_CHARGE: begin
                rec_kind  = REC_CHARGE;
                rec_value = charge_sel;
            end
            default: begin
                rec_kind  = REC_HEADER;
                rec_value = '0;
            end
        endcase
    end

    // Detector id, modulo 4096
    always_comb begin
        crate_part = 12'(12'(r_w0[11:8]) * 12'(i_cfg.board_span));
        slot_part  = 12'((12'(r_w0[7:4]) - 12'(i_cfg.first_slot))
                         * 12'(i_cfg.channels_per_board));
        det_id     = crate_part + slot_part + 12'(r_w0[3:0]);
    end

    always_comb begin
        n_state   = r_state;
        n_sum_idx = r_sum_idx;
        if (load) begin
            case (r_state)
                S_HDR: begin
                    n_sum_idx = '0;
                    if (r_emit_energy)      n_state = S_ENERGY;
                    else if (r_emit_charge) n_state = S_CHARGE;
                    else                    n_state = S_RUN;
                end
                S_ENERGY: begin
                    if (r_sum_idx == SUM_IDX_W'(3)) begin
                        n_sum_idx = '0;
                        n_state   = r_emit_charge ? S_CHARGE : S_RUN;
                    end else begin
                        n_sum_idx = r_sum_idx + 1'b1;
                    end
                end
                S_CHARGE: begin
                    if (rec_last) n_state = S_RUN;
                    else          n_sum_idx = r_sum_idx + 1'b1;
                end
                default: n_state = S_RUN;
            endcase
        end
        if (pop && i_op.last) begin
            n_state   = S_HDR;
            n_sum_idx = '0;
        end
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_RUN;
            r_sum_idx     <= '0;
            r_emit_energy <= 1'b0;
            r_emit_charge <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sum_idx <= n_sum_idx;
            if (pop && i_op.last) begin
                r_emit_energy <= i_op.emit_energy;
                r_emit_charge <= i_op.emit_charge;
            end
            if (load) begin
                r_out_valid     <= 1'b1;
                r_out_kind      <= rec_kind;
                r_out_id        <= det_id;
                r_out_w0        <= r_w0;
                r_out_w1        <= r_w1;
                r_out_w2        <= r_w2;
                r_out_w3        <= r_w3;
                r_out_idx       <= (r_state == S_HDR) ? '0 : r_sum_idx;
                r_out_sum_value <= rec_value;
                r_out_last      <= rec_last;
            end else if (i_out_ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    // Header capture and sum accumulation
    assign lo_sample = i_op.word[15:0];
    assign hi_sample = i_op.word[31:16];

    always_ff @(posedge i_clk) begin
        if (pop) begin
            case (i_op.kind)
                OP_HDR0: begin
                    r_w0 <= i_op.word;
                    for (int k = 0; k < 4; k++) r_energy[k] <= '0;
                    for (int k = 0; k < SUM_WINDOWS; k++) r_charge[k] <= '0;
                end
                OP_HDR1: r_w1 <= i_op.word;
                OP_HDR2: r_w2 <= i_op.word;
                OP_HDR3: r_w3 <= i_op.word;
                OP_ENERGY: r_energy[i_op.idx[1:0]] <= i_op.word;
                OP_CHARGE: begin
                    for (int k = 0; k < SUM_WINDOWS; k++) begin
                        if (i_op.idx == SUM_IDX_W'(k)) r_charge[k] <= i_op.word;
                    end
                end
                OP_TRACE: begin
                    for (int k = 0; k < SUM_WINDOWS; k++) begin
                        r_charge[k] <= r_charge[k]
                            + ((i_op.lo_hit && i_op.lo_win == SUM_IDX_W'(k))
                               ? 32'(lo_sample) : 32'd0)
                            + ((i_op.hi_hit && i_op.hi_win == SUM_IDX_W'(k))
                               ? 32'(hi_sample) : 32'd0);
                    end
                end
                default: ;
            endcase
        end
    end

    // Output fields
    assign o_out_valid    = r_out_valid;
    assign o_record_kind  = r_out_kind;
    assign o_detector_id  = r_out_id;
    assign o_finish_code  = r_out_w0[31];
    assign o_timestamp    = {r_out_w2[15:0], r_out_w1};
    assign o_cfd_time     = r_out_w2[30:16];
    assign o_cfd_fail     = r_out_w2[31];
    assign o_energy       = r_out_w3[15:0];
    assign o_trace_length = r_out_w3[30:16];
    assign o_out_of_range = r_out_w3[31];
    assign o_sum_index    = r_out_idx;
    assign o_sum_value    = r_out_sum_value;
    assign o_last_record  = r_out_last;

    // Checks
    a_end_starts_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_op.last |=> r_state == S_HDR)
        else $error("event end did not start record output");

    a_charge_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHARGE |-> {1'b0, r_sum_idx} < (SUM_IDX_W+1)'(SUM_WINDOWS))
        else $error("charge sum index out of range");

    a_energy_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ENERGY |-> r_emit_energy)
        else $error("energy records without energy sums");

    a_hdr_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_state == S_HDR |=> r_out_valid && r_out_kind == REC_HEADER
                                     && r_out_sum_value == '0 && r_out_idx == '0)
        else $error("malformed header record");

endmodule

`default_nettype wire

// ===== rtl/digitizer_event_unpacker_top.sv =====
// ============================================================================
// digitizer_event_unpacker_top: list-mode digitizer event unpacker
// Decodes a stream of 32-bit event words into header, energy-sum and
// charge-sum records, with configurable detector id mapping.
// ============================================================================
// The block takes one stream word per clock as long as its four-entry word
// queue has room; the classifier keeps no other back pressure. Every word
// that ends an event makes the record generator emit 1, 5, 1 + SUM_WINDOWS
// or 1 + 4 + SUM_WINDOWS records at one per clock while the output is ready,
// the first once the word has passed the state register and the output
// register; while it does so it reads no further words, so the sustained
// input rate is one word per cycle for trace-bearing events and is bounded
// by the record output rate for very short events. Configuration writes are
// always accepted; the crate stride is registered from the stored fields.
`default_nettype none

module digitizer_event_unpacker_top #(
    parameter int SUM_WINDOWS = 8,
    parameter int SAMPLE_BITS = 14
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // stream words
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [31:0]    i_data_word,
    // records
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [1:0]          o_record_kind,
    output logic [11:0]         o_detector_id,
    output logic                o_finish_code,
    output logic [47:0]         o_timestamp,
    output logic [14:0]         o_cfd_time,
    output logic                o_cfd_fail,
    output logic [15:0]         o_energy,
    output logic [14:0]         o_trace_length,
    output logic                o_out_of_range,
    output logic [2:0]          o_sum_index,
    output logic [31:0]         o_sum_value,
    output logic                o_last_record,
    // configuration writes
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [4:0]     i_cfg_data
);
    import deu_pkg::*;

    localparam logic [1:0] CFG_FIRST_SLOT         = 2'd0;
    localparam logic [1:0] CFG_BOARDS_PER_CRATE   = 2'd1;
    localparam logic [1:0] CFG_CHANNELS_PER_BOARD = 2'd2;

    logic [3:0] r_first_slot;
    logic [4:0] r_boards_per_crate;
    logic [4:0] r_channels_per_board;
    logic [9:0] r_board_span;
    t_cfg       cfg;

    logic       push;
    logic       q_ready;
    logic       q_valid;
    logic       q_pop;
    t_op        front_op;
    t_op        q_op;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_slot         <= 4'd2;
            r_boards_per_crate   <= 5'd13;
            r_channels_per_board <= 5'd16;
            r_board_span         <= 10'd208;
        end else begin
            r_board_span <= 10'(r_boards_per_crate * r_channels_per_board);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FIRST_SLOT:         r_first_slot         <= i_cfg_data[3:0];
                    CFG_BOARDS_PER_CRATE:   r_boards_per_crate   <= i_cfg_data;
                    CFG_CHANNELS_PER_BOARD: r_channels_per_board <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        cfg.first_slot         = r_first_slot;
        cfg.channels_per_board = r_channels_per_board;
        cfg.board_span         = r_board_span;
    end

    // Input transaction goes straight into the queue
    assign o_in_ready = q_ready;
    assign push       = i_in_valid && q_ready;

    deu_front #(
        .SUM_WINDOWS (SUM_WINDOWS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (push),
        .i_word   (i_data_word),
        .o_op     (front_op)
    );

    deu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    deu_back #(
        .SUM_WINDOWS (SUM_WINDOWS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_op_valid     (q_valid),
        .i_op           (q_op),
        .o_op_pop       (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_record_kind  (o_record_kind),
        .o_detector_id  (o_detector_id),
        .o_finish_code  (o_finish_code),
        .o_timestamp    (o_timestamp),
        .o_cfd_time     (o_cfd_time),
        .o_cfd_fail     (o_cfd_fail),
        .o_energy       (o_energy),
        .o_trace_length (o_trace_length),
        .o_out_of_range (o_out_of_range),
        .o_sum_index    (o_sum_index),
        .o_sum_value    (o_sum_value),
        .o_last_record  (o_last_record)
    );

endmodule

`default_nettype wire

// ===== dv/digitizer_event_unpacker_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// digitizer_event_unpacker_top_tb: self-checking bench for the event unpacker
// Feeds event streams word by word over the input transaction channel and
// checks every header, energy-sum and charge-sum record against an internal
// decoder of the stream. Covers a short table of edge-case events, then
// random events over several detector-id mappings, with bursty input,
// patterned output stalls and one long output hold-off that backs up the
// input.
// ============================================================================

module digitizer_event_unpacker_top_tb;

    import deu_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;

    // Configuration register indexes
    localparam int REG_FIRST_SLOT         = 0;
    localparam int REG_BOARDS_PER_CRATE   = 1;
    localparam int REG_CHANNELS_PER_BOARD = 2;
    localparam int REG_COUNT              = 3;

    // Charge-sum window edges in samples
    localparam int unsigned WIN_EDGE [9] = '{0, 31, 60, 75, 95, 105, 160, 175, 200};

    // One output record
    typedef struct packed {
        t_rec_kind   kind;
        logic [11:0] det_id;
        logic        finish;
        logic [47:0] stamp;
        logic [14:0] cfd;
        logic        cfd_fail;
        logic [15:0] energy;
        logic [14:0] trace_len;
        logic        oor;
        logic [2:0]  sum_idx;
        logic [31:0] sum_val;
        logic        last_rec;
    } record_t;

    // One row of the directed table; n_rec and det_id hold only where typed is set
    typedef struct packed {
        logic [31:0] word;
        logic        typed;
        logic [3:0]  n_rec;
        logic [11:0] det_id;
    } step_row_t;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [31:0] i_data_word = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [4:0]  i_cfg_data  = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_record_kind;
    logic [11:0] o_detector_id;
    logic        o_finish_code;
    logic [47:0] o_timestamp;
    logic [14:0] o_cfd_time;
    logic        o_cfd_fail;
    logic [15:0] o_energy;
    logic [14:0] o_trace_length;
    logic        o_out_of_range;
    logic [2:0]  o_sum_index;
    logic [31:0] o_sum_value;
    logic        o_last_record;
    logic        o_cfg_ready;

    digitizer_event_unpacker_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_word    (i_data_word),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_record_kind  (o_record_kind),
        .o_detector_id  (o_detector_id),
        .o_finish_code  (o_finish_code),
        .o_timestamp    (o_timestamp),
        .o_cfd_time     (o_cfd_time),
        .o_cfd_fail     (o_cfd_fail),
        .o_energy       (o_energy),
        .o_trace_length (o_trace_length),
        .o_out_of_range (o_out_of_range),
        .o_sum_index    (o_sum_index),
        .o_sum_value    (o_sum_value),
        .o_last_record  (o_last_record),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Decoder state, mirrors the block
    logic [3:0]  cfg_first_slot   = 4'd2;
    logic [4:0]  cfg_boards       = 5'd13;
    logic [4:0]  cfg_channels     = 5'd16;
    int unsigned ev_pos           = 0;
    logic [31:0] ev_hdr [4]       = '{default: '0};
    logic [13:0] ev_len           = '0;
    logic [4:0]  hdr_len          = '0;
    logic [31:0] q_sum [8]        = '{default: '0};
    logic [31:0] e_sum [4]        = '{default: '0};
    logic [11:0] last_hdr_id      = '0;

    record_t     pending_records [$];
    step_row_t   dir_rows [$];
    int          err_count        = 0;
    int          records_checked  = 0;
    int          predicted_total  = 0;
    int          cycle_count      = 0;
    int          burst_left       = 0;
    bit          hold_req         = 1'b0;
    bit          hold_done        = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 50) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [47:0] got,
                               input logic [47:0] want);
        if (got !== want)
            flag_error($sformatf("record %0d %s: got %0h, expected %0h",
                                 records_checked, name, got, want));
    endtask

    // Header word 0 from its fields
    function automatic logic [31:0] hdr0(input int unsigned fin, ev_words, hdr_words,
                                         crate, slot, chan);
        return {1'(fin), 14'(ev_words), 5'(hdr_words), 4'(crate), 4'(slot), 4'(chan)};
    endfunction

    // Decode one stream word; queues the records it completes and returns their count
    function automatic int decode_word(input logic [31:0] w);
        int unsigned j, base, idx;
        logic [31:0] smp, id_full;
        logic [14:0] tl;
        bit          hdr_q, done;
        record_t     rec;
        record_t     batch [$];

        done = 1'b0;
        case (ev_pos)
            0: begin
                ev_hdr  = '{w, 32'h0, 32'h0, 32'h0};
                hdr_len = w[16:12];
                ev_len  = w[30:17];
                q_sum   = '{default: '0};
                e_sum   = '{default: '0};
            end
            1: ev_hdr[1] = w;
            2: ev_hdr[2] = w;
            3: ev_hdr[3] = w;
            default: begin
                if (ev_pos < hdr_len) begin
                    // header-supplied energy and charge sums
                    j = ev_pos - 4;
                    if ((hdr_len == 8 || hdr_len == 16) && j < 4) e_sum[j] = w;
                    if (hdr_len == 12 && j < 8) q_sum[j] = w;
                    if (hdr_len == 16 && j >= 4 && j < 12) q_sum[j-4] = w;
                end else if (!(hdr_len == 12 || hdr_len == 16)) begin
                    // trace word: two samples, low half first
                    base = (hdr_len > 4) ? hdr_len : 4;
                    tl   = ev_hdr[3][30:16];
                    for (int h = 0; h < 2; h++) begin
                        idx = (ev_pos - base) * 2 + h;
                        smp = (h == 0) ? {18'b0, w[13:0]} : {18'b0, w[29:16]};
                        if (idx < tl)
                            for (int k = 0; k < 8; k++)
                                if (idx >= WIN_EDGE[k] && idx < WIN_EDGE[k+1])
                                    q_sum[k] = q_sum[k] + smp;
                    end
                end
            end
        endcase

        // End of event
        tl    = ev_hdr[3][30:16];
        hdr_q = (hdr_len == 12 || hdr_len == 16);
        if (ev_pos == 3) begin
            if (hdr_len == 4 && tl < 2) begin
                ev_pos = 0;
                return 0;
            end
            done = (ev_len <= 4);
        end else if (ev_pos >= 4 && ev_pos + 1 >= ev_len) begin
            done = 1'b1;
        end
        if (!done) begin
            ev_pos = ev_pos + 1;
            return 0;
        end
        ev_pos = 0;

        id_full = 32'(ev_hdr[0][11:8]) * 32'(cfg_boards) * 32'(cfg_channels)
                + (32'(ev_hdr[0][7:4]) - 32'(cfg_first_slot)) * 32'(cfg_channels)
                + 32'(ev_hdr[0][3:0]);
        last_hdr_id   = id_full[11:0];
        rec.kind      = REC_HEADER;
        rec.det_id    = id_full[11:0];
        rec.finish    = ev_hdr[0][31];
        rec.stamp     = {ev_hdr[2][15:0], ev_hdr[1]};
        rec.cfd       = ev_hdr[2][30:16];
        rec.cfd_fail  = ev_hdr[2][31];
        rec.energy    = ev_hdr[3][15:0];
        rec.trace_len = tl;
        rec.oor       = ev_hdr[3][31];
        rec.sum_idx   = '0;
        rec.sum_val   = '0;
        rec.last_rec  = 1'b0;
        batch.push_back(rec);
        if (hdr_len == 8 || hdr_len == 16)
            for (int k = 0; k < 4; k++) begin
                rec.kind    = REC_ENERGY;
                rec.sum_idx = 3'(k);
                rec.sum_val = e_sum[k];
                batch.push_back(rec);
            end
        if (tl != 0 || hdr_q)
            for (int k = 0; k < 8; k++) begin
                rec.kind    = REC_CHARGE;
                rec.sum_idx = 3'(k);
                rec.sum_val = q_sum[k];
                batch.push_back(rec);
            end
        batch[batch.size()-1].last_rec = 1'b1;
        foreach (batch[b]) pending_records.push_back(batch[b]);
        return batch.size();
    endfunction

    // Offer one word in bursts with random gaps; decode it once the transaction completes
    task automatic feed_word(input logic [31:0] w, output int n_rec);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_data_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        n_rec = decode_word(w);
        predicted_total += n_rec;
    endtask

    // One random event; longest gives the maximum event length
    task automatic send_event(input bit longest, inout int words_sent);
        int unsigned pick, hwords, ewords, ntrace, tlen;
        logic [31:0] w0, w3, rnd;
        int          nw, n;

        pick = $urandom_range(0, 99);
        if (longest) begin
            hwords = 4; ewords = 16383; tlen = 32767;
        end else if (pick < 15) begin
            // header only
            hwords = 4; ewords = $urandom_range(0, 20); tlen = $urandom_range(0, 1);
        end else if (pick < 30) begin
            // energy sums, all four words always present
            hwords = $urandom_range(0, 1) ? 16 : 8;
            ewords = $urandom_range(8, hwords + 8);
            tlen   = $urandom_range(0, 40);
        end else if (pick < 42) begin
            hwords = 12; ewords = $urandom_range(0, 20); tlen = $urandom_range(0, 40);
        end else if (pick < 85) begin
            // trace summed into windows
            do hwords = $urandom_range(0, 31); while (hwords == 8 || hwords == 12 || hwords == 16);
            ntrace = ($urandom_range(0, 7) == 0) ? $urandom_range(95, 110) : $urandom_range(0, 12);
            ewords = ((hwords > 4) ? hwords : 4) + ntrace;
            case ($urandom_range(0, 2))
                0:       tlen = 2 * ntrace;
                1:       tlen = $urandom_range(0, 2 * ntrace + 3);
                default: tlen = $urandom_range(0, 32767);
            endcase
        end else begin
            // random header fields
            hwords = $urandom_range(0, 31);
            ewords = $urandom_range(0, 40);
            tlen   = $urandom_range(0, 32767);
            if ((hwords == 8 || hwords == 16) && ewords < 8) ewords = 8 + $urandom_range(0, 8);
        end

        w0  = hdr0($urandom_range(0, 1), ewords, hwords, $urandom_range(0, 15),
                   $urandom_range(0, 15), $urandom_range(0, 15));
        rnd = $urandom;
        w3  = {rnd[31], 15'(tlen), rnd[15:0]};
        nw  = ((hwords == 4 && tlen < 2) || ewords <= 4) ? 4 : int'(ewords);
        for (int k = 0; k < nw; k++)
            feed_word((k == 0) ? w0 : (k == 3) ? w3 : $urandom, n);
        words_sent += nw;
    endtask

    // Hold input off until every pending record is out, then let the pipe empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all registers back to back, valid held across the transactions
    task automatic apply_config(input logic [4:0] fs, bpc, cpb);
        logic [4:0] val [REG_COUNT];
        val[REG_FIRST_SLOT]         = fs;
        val[REG_BOARDS_PER_CRATE]   = bpc;
        val[REG_CHANNELS_PER_BOARD] = cpb;
        for (int r = 0; r < REG_COUNT; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 2'(r);
            i_cfg_data  <= val[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (r)
                REG_FIRST_SLOT:       cfg_first_slot = val[r][3:0];
                REG_BOARDS_PER_CRATE: cfg_boards     = val[r];
                default:              cfg_channels   = val[r];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Record checker
    always @(posedge i_clk) begin : record_check
        record_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_records.size() == 0) begin
                flag_error("record transaction with no record pending");
            end else begin
                want = pending_records.pop_front();
                check_field("record_kind", o_record_kind, want.kind);
                check_field("detector_id", o_detector_id, want.det_id);
                check_field("finish_code", o_finish_code, want.finish);
                check_field("timestamp", o_timestamp, want.stamp);
                check_field("cfd_time", o_cfd_time, want.cfd);
                check_field("cfd_fail", o_cfd_fail, want.cfd_fail);
                check_field("energy", o_energy, want.energy);
                check_field("trace_length", o_trace_length, want.trace_len);
                check_field("out_of_range", o_out_of_range, want.oor);
                check_field("sum_index", o_sum_index, want.sum_idx);
                check_field("sum_value", o_sum_value, want.sum_val);
                check_field("last_record", o_last_record, want.last_rec);
            end
            records_checked++;
        end
    end

    // Output stalls: random segments of patterns, one long hold-off on request
    initial begin : record_sink
        int mode, seg_left;
        seg_left = 0;
        mode     = 0;
        forever begin
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(16, 120);
                end
                seg_left--;
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 9) < 6);
                    2:       i_out_ready <= (seg_left % 4 != 3);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        int n, phase_words, long_words, rand_base;

        // header-only event, short all-ones event, header-supplied sums with slot
        // below the first slot
        dir_rows = '{
            '{hdr0(0, 4, 4, 0, 2, 0),    1'b0, 4'd0,  12'h000},
            '{32'h0000_0000,             1'b0, 4'd0,  12'h000},
            '{32'hFFFF_FFFF,             1'b0, 4'd0,  12'h000},
            '{32'h0001_1234,             1'b1, 4'd0,  12'h000},
            '{hdr0(1, 0, 4, 15, 15, 15), 1'b0, 4'd0,  12'h000},
            '{32'hFFFF_FFFF,             1'b0, 4'd0,  12'h000},
            '{32'hFFFF_FFFF,             1'b0, 4'd0,  12'h000},
            '{32'hFFFF_FFFF,             1'b1, 4'd9,  12'hD0F},
            '{hdr0(0, 16, 16, 0, 0, 0),  1'b0, 4'd0,  12'h000},
            '{32'h0000_0000,             1'b0, 4'd0,  12'h000},
            '{32'h0000_0000,             1'b0, 4'd0,  12'h000},
            '{32'h0000_0000,             1'b0, 4'd0,  12'h000},
            '{32'hFFFF_FFFF,             1'b0, 4'd0,  12'h000},
            '{32'h0000_0000,             1'b0, 4'd0,  12'h000},
            '{32'h1234_5678,             1'b0, 4'd0,  12'h000},
            '{32'h8000_0001,             1'b0, 4'd0,  12'h000},
            '{32'hFFFF_FFFF,             1'b0, 4'd0,  12'h000},
            '{32'h0000_0001,             1'b0, 4'd0,  12'h000},
            '{32'h7FFF_FFFF,             1'b0, 4'd0,  12'h000},
            '{32'h8000_0000,             1'b0, 4'd0,  12'h000},
            '{32'h0000_FFFF,             1'b0, 4'd0,  12'h000},
            '{32'hFFFF_0000,             1'b0, 4'd0,  12'h000},
            '{32'hA5A5_A5A5,             1'b0, 4'd0,  12'h000},
            '{32'h5A5A_5A5A,             1'b1, 4'd13, 12'hFE0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed events at reset configuration
        foreach (dir_rows[r]) begin
            feed_word(dir_rows[r].word, n);
            if (dir_rows[r].typed &&
                (n != dir_rows[r].n_rec || (n != 0 && last_hdr_id != dir_rows[r].det_id)))
                flag_error($sformatf("row %0d: %0d records id %0h, expected %0d id %0h",
                                     r, n, last_hdr_id, dir_rows[r].n_rec,
                                     dir_rows[r].det_id));
        end

        // Random events over several id mappings
        rand_base  = predicted_total;
        long_words = 0;
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0:       apply_config(5'd0, 5'd1, 5'd1);
                1:       apply_config(5'd15, 5'd16, 5'd16);
                2:       apply_config(5'($urandom_range(0, 15)), 5'($urandom_range(1, 16)),
                                      5'($urandom_range(1, 16)));
                default: apply_config(5'd2, 5'd13, 5'd16);
            endcase
            // output holds off while input keeps coming
            if (ph == 1) hold_req = 1'b1;
            if (ph == 3) send_event(1'b1, long_words);
            phase_words = 0;
            while (phase_words < 45 || (ph == 3 && predicted_total - rand_base < 60))
                send_event(1'b0, phase_words);
        end
        settle();

        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
